FILE: rtl/ddwg_pkg.sv
package ddwg_pkg;

   // field and state widths
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 15;
   localparam int LEVEL_W   = 31;
   localparam int SUM_W     = 38;
   localparam int FRAME_W   = 7;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 48;
   localparam int CSR_IW    = 1;
   localparam int CSR_DW    = 15;

   // gain divider: one quotient bit per stage
   localparam int DIV_STEPS = 15;
   // noise average divider: one quotient bit per cycle
   localparam int AVG_STEPS = 38;
   localparam int AVG_CW    = 6;

   localparam logic [LEVEL_W-1:0] SAT31      = 31'h7FFF_FFFF;
   localparam logic [GAIN_W-1:0]  Q15_MAX    = 15'h7FFF;
   localparam logic [GAIN_W-1:0]  ALPHA_RST  = 15'd32113;
   localparam logic [FRAME_W-1:0] PROF_RST   = 7'd13;
   localparam logic [FRAME_W-1:0] FRAMES_MAX = 7'd127;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_ALPHA   = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_PROFILE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_WRITE
   } sweep_state_type;

endpackage

FILE: rtl/ddwg_ram.sv
module ddwg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/decision_directed_wiener_gain.sv
// channel | dir | signals                        | contents
// req     | in  | req_tvalid/tready/tdata        | re_in, im_in
// rsp     | out | rsp_tvalid/tready/tdata/tlast/ | re_out, im_out, gain;
//         |     | tuser                          | tlast frame_end, tuser filtering
// csr     | in  | csr_we/index/wdata             | alpha_q15, profile_frames
//
// one bin per cycle when not stalled, through a 25-stage pipeline plus output
// register; the 15-stage gain divider sets the depth.
// after reset the noise sums are cleared before the first beat.
// after the last profiling frame the pipeline drains, then the averaging sweep
// reads, divides and writes each bin (one quotient bit per cycle, own divider).
// a stalled output freezes every stage; a bin still in flight holds off the next
// beat of the same bin.
module decision_directed_wiener_gain #(
   parameter int BINS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ddwg_pkg::REQ_W-1:0]   req_tdata,   // re_in[15:0], im_in[31:16]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ddwg_pkg::RSP_W-1:0]   rsp_tdata,   // re_out[15:0], im_out[31:16],
                                                     // gain[46:32], zero[47]
   output logic                         rsp_tlast,   // frame_end
   output logic                         rsp_tuser,   // filtering
   input  logic                         csr_we,
   input  logic [ddwg_pkg::CSR_IW-1:0]  csr_index,
   input  logic [ddwg_pkg::CSR_DW-1:0]  csr_wdata
);

   import ddwg_pkg::*;

   localparam int BW  = $clog2(BINS);
   localparam int NST = 25;
   localparam int S_SETUP = 6;
   localparam int S_GAIN  = S_SETUP + DIV_STEPS + 1;
   localparam int S_ROUND = S_GAIN + 1;
   localparam int S_OPWR  = S_ROUND + 1;
   localparam logic [BW-1:0] LAST_BIN = BW'(BINS - 1);

   typedef struct packed {
      logic                       valid;
      logic [BW-1:0]              bin;
      logic                       last;
      logic                       filt;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic [SUM_W-1:0]           nsum;
      logic [LEVEL_W-1:0]         nz;
      logic [LEVEL_W-1:0]         clean;
      logic [31:0]                pa;
      logic [31:0]                pb;
      logic [LEVEL_W-1:0]         pw;
      logic [LEVEL_W-1:0]         excess;
      logic [45:0]                ma;
      logic [45:0]                mb;
      logic [LEVEL_W-1:0]         num;
      logic [31:0]                den;
      logic [31:0]                rem;
      logic [GAIN_W-1:0]          dlo;
      logic [GAIN_W-1:0]          q;
      logic [GAIN_W-1:0]          gain;
      logic signed [31:0]         sa;
      logic signed [31:0]         sb;
      logic signed [SAMPLE_W-1:0] ore;
      logic signed [SAMPLE_W-1:0] oim;
   } pipe_type;

   pipe_type p_ff [NST];
   pipe_type p_in [NST];

   sweep_state_type state_ff, state_in;

   logic [BW-1:0]       bin_ff;
   logic [FRAME_W-1:0]  frames_ff;
   logic                known_ff;
   logic [GAIN_W-1:0]   alpha_ff;
   logic [FRAME_W-1:0]  prof_ff;
   logic [FRAME_W-1:0]  div_ff;
   logic [BW-1:0]       cnt_ff;
   logic [AVG_CW-1:0]   step_ff;
   logic [SUM_W-1:0]    dd_ff;
   logic [FRAME_W-1:0]  dr_ff;
   logic [SUM_W-1:0]    dq_ff;

   logic                    out_v_ff;
   logic [SAMPLE_W-1:0]     out_re_ff;
   logic [SAMPLE_W-1:0]     out_im_ff;
   logic [GAIN_W-1:0]       out_gain_ff;
   logic                    out_last_ff;
   logic                    out_filt_ff;

   logic                advance;
   logic                hazard;
   logic                busy;
   logic                accept;
   logic                last_bin;
   logic [FRAME_W-1:0]  div_cur;
   logic [FRAME_W-1:0]  frames_next;
   logic                trigger;

   logic                ns_we, ns_re;
   logic [BW-1:0]       ns_waddr, ns_raddr;
   logic [SUM_W-1:0]    ns_wdata, ns_rdata;
   logic                nl_we;
   logic [LEVEL_W-1:0]  nl_rdata;
   logic                cl_we;
   logic [BW-1:0]       cl_waddr;
   logic [LEVEL_W-1:0]  cl_wdata, cl_rdata;
   logic [LEVEL_W-1:0]  avg_val;
   logic [32:0]         opwr_sum;
   logic [LEVEL_W-1:0]  opwr;
   logic [FRAME_W:0]    avg_r2;

   // handshake and frame bookkeeping
   assign advance     = !out_v_ff || rsp_tready;
   assign last_bin    = (bin_ff == LAST_BIN);
   assign div_cur     = (prof_ff == '0) ? FRAME_W'(1) : prof_ff;
   assign frames_next = (frames_ff == FRAMES_MAX) ? FRAMES_MAX : frames_ff + FRAME_W'(1);
   assign req_tready  = advance && (state_ff == ST_RUN) && !hazard;
   assign accept      = req_tvalid && req_tready;
   assign trigger     = accept && !known_ff && last_bin && (frames_next >= div_cur);

   // same bin still in flight, or anything in flight
   always_comb begin
      hazard = 1'b0;
      busy   = 1'b0;
      for (int i = 0; i < NST; i++) begin
         if (p_ff[i].valid) begin
            busy = 1'b1;
            if (p_ff[i].bin == bin_ff) begin
               hazard = 1'b1;
            end
         end
      end
   end

   // pipeline stage logic
   always_comb begin
      logic [32:0] psum;
      logic [46:0] msum;
      logic [31:0] mshift;
      logic [45:0] dvd;
      logic [32:0] r2;

      p_in[0]       = '0;
      p_in[0].valid = accept;
      p_in[0].bin   = bin_ff;
      p_in[0].last  = last_bin;
      p_in[0].filt  = known_ff;
      p_in[0].re    = req_tdata[15:0];
      p_in[0].im    = req_tdata[31:16];

      for (int i = 1; i < NST; i++) begin
         p_in[i] = p_ff[i-1];
      end

      // input power products and state read
      p_in[1].pa    = 32'($signed(p_ff[0].re) * $signed(p_ff[0].re));
      p_in[1].pb    = 32'($signed(p_ff[0].im) * $signed(p_ff[0].im));
      p_in[1].nsum  = ns_rdata;
      p_in[1].nz    = (nl_rdata == '0) ? LEVEL_W'(1) : nl_rdata;
      p_in[1].clean = cl_rdata;

      // saturated input power
      psum = {1'b0, p_ff[1].pa} + {1'b0, p_ff[1].pb};
      p_in[2].pw = (psum > {2'b0, SAT31}) ? SAT31 : psum[LEVEL_W-1:0];

      // power above the noise floor
      p_in[3].excess = (p_ff[2].pw > p_ff[2].nz) ? p_ff[2].pw - p_ff[2].nz : '0;

      // weighted terms
      p_in[4].ma = 46'(alpha_ff * p_ff[3].clean);
      p_in[4].mb = 46'((Q15_MAX - alpha_ff) * p_ff[3].excess);

      // numerator
      msum   = {1'b0, p_ff[4].ma} + {1'b0, p_ff[4].mb};
      mshift = msum[46:15];
      p_in[5].num = (mshift > {1'b0, SAT31}) ? SAT31 : mshift[LEVEL_W-1:0];

      // divider setup: num*32767 over num+noise
      dvd = {p_ff[5].num, 15'b0} - {15'b0, p_ff[5].num};
      p_in[S_SETUP].den = {1'b0, p_ff[5].num} + {1'b0, p_ff[5].nz};
      p_in[S_SETUP].rem = {1'b0, dvd[45:15]};
      p_in[S_SETUP].dlo = dvd[14:0];
      p_in[S_SETUP].q   = '0;

      // restoring divider, one quotient bit per stage
      for (int k = 0; k < DIV_STEPS; k++) begin
         r2 = {p_ff[S_SETUP+k].rem, p_ff[S_SETUP+k].dlo[GAIN_W-1]};
         p_in[S_SETUP+k+1].dlo = {p_ff[S_SETUP+k].dlo[GAIN_W-2:0], 1'b0};
         if (r2 >= {1'b0, p_ff[S_SETUP+k].den}) begin
            p_in[S_SETUP+k+1].rem = 32'(r2 - {1'b0, p_ff[S_SETUP+k].den});
            p_in[S_SETUP+k+1].q   = {p_ff[S_SETUP+k].q[GAIN_W-2:0], 1'b1};
         end else begin
            p_in[S_SETUP+k+1].rem = r2[31:0];
            p_in[S_SETUP+k+1].q   = {p_ff[S_SETUP+k].q[GAIN_W-2:0], 1'b0};
         end
      end

      // gain and scaling products
      p_in[S_GAIN].gain = p_ff[S_GAIN-1].filt ? p_ff[S_GAIN-1].q : Q15_MAX;
      p_in[S_GAIN].sa   = $signed(p_ff[S_GAIN-1].re)
                        * $signed({1'b0, p_in[S_GAIN].gain});
      p_in[S_GAIN].sb   = $signed(p_ff[S_GAIN-1].im)
                        * $signed({1'b0, p_in[S_GAIN].gain});

      // arithmetic shift, rounds toward minus infinity
      p_in[S_ROUND].ore = p_ff[S_GAIN].filt ? p_ff[S_GAIN].sa[30:15] : p_ff[S_GAIN].re;
      p_in[S_ROUND].oim = p_ff[S_GAIN].filt ? p_ff[S_GAIN].sb[30:15] : p_ff[S_GAIN].im;

      // output power products
      p_in[S_OPWR].pa = 32'($signed(p_ff[S_ROUND].ore) * $signed(p_ff[S_ROUND].ore));
      p_in[S_OPWR].pb = 32'($signed(p_ff[S_ROUND].oim) * $signed(p_ff[S_ROUND].oim));
   end

   // saturated output power for the clean level
   assign opwr_sum = {1'b0, p_ff[NST-1].pa} + {1'b0, p_ff[NST-1].pb};
   assign opwr     = (opwr_sum > {2'b0, SAT31}) ? SAT31 : opwr_sum[LEVEL_W-1:0];

   // averaged noise level, clamped
   always_comb begin
      if (dq_ff > {{(SUM_W-LEVEL_W){1'b0}}, SAT31}) begin
         avg_val = SAT31;
      end else if (dq_ff == '0) begin
         avg_val = LEVEL_W'(1);
      end else begin
         avg_val = dq_ff[LEVEL_W-1:0];
      end
   end

   assign avg_r2 = {dr_ff, dd_ff[SUM_W-1]};

   // sweep next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (cnt_ff == LAST_BIN) state_in = ST_RUN;
         ST_RUN:   if (trigger) state_in = ST_DRAIN;
         ST_DRAIN: if (!busy) state_in = ST_READ;
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV:   if (step_ff == AVG_CW'(AVG_STEPS - 1)) state_in = ST_WRITE;
         ST_WRITE: state_in = (cnt_ff == LAST_BIN) ? ST_RUN : ST_READ;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // memory port control
   always_comb begin
      ns_we    = 1'b0;
      ns_waddr = p_ff[2].bin;
      ns_wdata = p_ff[2].nsum + {{(SUM_W-LEVEL_W){1'b0}}, p_ff[2].pw};
      ns_re    = accept;
      ns_raddr = bin_ff;
      nl_we    = 1'b0;
      cl_we    = p_ff[NST-1].valid && p_ff[NST-1].filt && advance;
      cl_waddr = p_ff[NST-1].bin;
      cl_wdata = opwr;
      unique case (state_ff)
         ST_CLEAR: begin
            ns_we    = 1'b1;
            ns_waddr = cnt_ff;
            ns_wdata = '0;
         end
         ST_RUN, ST_DRAIN: begin
            ns_we = p_ff[2].valid && !p_ff[2].filt && advance;
         end
         ST_READ: begin
            ns_re    = 1'b1;
            ns_raddr = cnt_ff;
         end
         ST_WRITE: begin
            nl_we    = 1'b1;
            cl_we    = 1'b1;
            cl_waddr = cnt_ff;
            cl_wdata = avg_val;
         end
         default: begin
            ns_we = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         bin_ff    <= '0;
         frames_ff <= '0;
         known_ff  <= 1'b0;
         alpha_ff  <= ALPHA_RST;
         prof_ff   <= PROF_RST;
         div_ff    <= PROF_RST;
         step_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ALPHA:   alpha_ff <= csr_wdata;
               CSR_PROFILE: prof_ff  <= csr_wdata[FRAME_W-1:0];
               default:     alpha_ff <= alpha_ff;
            endcase
         end
         if (accept) begin
            bin_ff <= last_bin ? '0 : bin_ff + BW'(1);
            if (!known_ff && last_bin) begin
               frames_ff <= frames_next;
               div_ff    <= div_cur;
            end
         end
         unique case (state_ff)
            ST_CLEAR: cnt_ff <= cnt_ff + BW'(1);
            ST_DRAIN: cnt_ff <= '0;
            ST_LOAD:  step_ff <= '0;
            ST_DIV:   step_ff <= step_ff + AVG_CW'(1);
            ST_WRITE: begin
               cnt_ff <= cnt_ff + BW'(1);
               if (cnt_ff == LAST_BIN) begin
                  known_ff <= 1'b1;
               end
            end
            default: step_ff <= step_ff;
         endcase
      end
   end

   // noise average divider datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         dd_ff <= ns_rdata;
         dr_ff <= '0;
         dq_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         dd_ff <= {dd_ff[SUM_W-2:0], 1'b0};
         if (avg_r2 >= {1'b0, div_ff}) begin
            dr_ff <= FRAME_W'(avg_r2 - {1'b0, div_ff});
            dq_ff <= {dq_ff[SUM_W-2:0], 1'b1};
         end else begin
            dr_ff <= avg_r2[FRAME_W-1:0];
            dq_ff <= {dq_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            p_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int i = 0; i < NST; i++) begin
            p_ff[i] <= p_in[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= p_ff[NST-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_re_ff   <= p_ff[NST-1].ore;
         out_im_ff   <= p_ff[NST-1].oim;
         out_gain_ff <= p_ff[NST-1].gain;
         out_last_ff <= p_ff[NST-1].last;
         out_filt_ff <= p_ff[NST-1].filt;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, out_gain_ff, out_im_ff, out_re_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_filt_ff;

   // per-bin state
   ddwg_ram #(.WIDTH(SUM_W), .DEPTH(BINS)) u_noise_sum (
      .clock   (clock),
      .wr_en   (ns_we),
      .wr_addr (ns_waddr),
      .wr_data (ns_wdata),
      .rd_en   (ns_re),
      .rd_addr (ns_raddr),
      .rd_data (ns_rdata)
   );

   ddwg_ram #(.WIDTH(LEVEL_W), .DEPTH(BINS)) u_noise_level (
      .clock   (clock),
      .wr_en   (nl_we),
      .wr_addr (cnt_ff),
      .wr_data (avg_val),
      .rd_en   (accept),
      .rd_addr (bin_ff),
      .rd_data (nl_rdata)
   );

   ddwg_ram #(.WIDTH(LEVEL_W), .DEPTH(BINS)) u_clean_level (
      .clock   (clock),
      .wr_en   (cl_we),
      .wr_addr (cl_waddr),
      .wr_data (cl_wdata),
      .rd_en   (accept),
      .rd_addr (bin_ff),
      .rd_data (cl_rdata)
   );

endmodule

FILE: rtl/ddwg_checker.sv
module ddwg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ddwg_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tuser
);

   import ddwg_pkg::*;

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // input not ready right after reset, while noise sums are being cleared
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input ready during clearing sweep");

   // pass-through beats carry unity gain
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[46:32] == Q15_MAX)
      else $error("pass-through beat without unity gain");

   // zero gain silences the bin
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[46:32] == '0 |-> rsp_tdata[31:0] == '0)
      else $error("zero gain with nonzero output");

endmodule

bind decision_directed_wiener_gain ddwg_checker u_ddwg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: verif/tb_decision_directed_wiener_gain.sv
`timescale 1ns / 100ps

module tb_decision_directed_wiener_gain;

   localparam int NBINS     = 256;
   localparam int HALF_T    = 2;
   localparam int IDLE_MAX  = 60000;
   localparam int TAIL_WAIT = 80;

   typedef struct packed {
      logic [15:0] re;
      logic [15:0] im;
      logic [14:0] gain;
      logic        filt;
      logic        last;
   } bin_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [ddwg_pkg::REQ_W-1:0]    req_tdata;   // re_in[15:0], im_in[31:16]
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [ddwg_pkg::RSP_W-1:0]    rsp_tdata;   // re_out[15:0], im_out[31:16], gain[46:32]
   logic                          rsp_tlast;   // frame_end
   logic                          rsp_tuser;   // filtering
   logic                          csr_we;
   logic [ddwg_pkg::CSR_IW-1:0]   csr_index;
   logic [ddwg_pkg::CSR_DW-1:0]   csr_wdata;

   // gain stage state as seen from outside
   longint      noise_acc [NBINS];
   longint      noise_lvl [NBINS];
   longint      clean_lvl [NBINS];
   int          frame_count;
   bit          profile_done;
   int          bin_idx;
   int          alpha_w;
   int          profile_len;

   bin_result_type pending_bins[$];
   int          mismatches;
   int          idle_cycles;
   int          burst_left;
   int          hold_left;
   bit          hold_request;
   int          stall_mode;
   int          mode_left;

   decision_directed_wiener_gain #(.BINS(NBINS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_T) clock = ~clock;

   function automatic longint sat_power(input longint re, input longint im);
      longint p;
      p = re * re + im * im;
      return (p > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : p;
   endfunction

   // expected beat for one accepted bin, state updated as the block does
   task automatic predict_bin(input logic signed [15:0] re, input logic signed [15:0] im);
      bin_result_type exp_bin;
      longint pw, nz, excess, num, g, re_o, im_o, avg;
      int div;
      pw = sat_power(re, im);
      exp_bin.last = (bin_idx == NBINS - 1);
      exp_bin.filt = profile_done;
      re_o = re;
      im_o = im;
      g = 32767;
      if (!profile_done) begin
         noise_acc[bin_idx] += pw;
         if (exp_bin.last) begin
            div = (profile_len == 0) ? 1 : profile_len;
            if (frame_count < 127) frame_count++;
            if (frame_count >= div) begin
               for (int j = 0; j < NBINS; j++) begin
                  avg = noise_acc[j] / div;
                  if (avg > 64'h7FFF_FFFF) avg = 64'h7FFF_FFFF;
                  if (avg < 1) avg = 1;
                  noise_lvl[j] = avg;
                  clean_lvl[j] = avg;
               end
               profile_done = 1'b1;
            end
         end
      end else begin
         nz = (noise_lvl[bin_idx] < 1) ? 1 : noise_lvl[bin_idx];
         excess = (pw > nz) ? pw - nz : 0;
         num = (longint'(alpha_w) * clean_lvl[bin_idx]
               + longint'(32767 - alpha_w) * excess) >>> 15;
         if (num > 64'h7FFF_FFFF) num = 64'h7FFF_FFFF;
         g = (num * 32767) / (num + nz);
         if (g > 32767) g = 32767;
         // arithmetic shift gives the floor for negative products
         re_o = (longint'(re) * g) >>> 15;
         im_o = (longint'(im) * g) >>> 15;
         clean_lvl[bin_idx] = sat_power(re_o, im_o);
      end
      bin_idx = exp_bin.last ? 0 : bin_idx + 1;
      exp_bin.re   = re_o[15:0];
      exp_bin.im   = im_o[15:0];
      exp_bin.gain = g[14:0];
      pending_bins.push_back(exp_bin);
   endtask

   // one input beat, with random burst gaps in front
   task automatic send_bin(input logic [15:0] re, input logic [15:0] im);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {im, re};
      do @(posedge clock); while (!req_tready);
      predict_bin(re, im);
   endtask

   // stop sending and let every expected beat come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_bins.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [ddwg_pkg::CSR_IW-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[14:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ddwg_pkg::CSR_ALPHA) alpha_w = value & 32'h7FFF;
      else profile_len = value & 32'h7F;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_sample(input int kind);
      case (kind)
         0:       return 16'(int'($urandom_range(0, 600)) - 300);
         1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         2:       return 16'(int'($urandom_range(0, 8000)) - 4000);
         default: return 16'($urandom);
      endcase
   endfunction

   // profiling: length changed mid-frame, a zero length, full-scale and silent bins
   task automatic test_noise_profile();
      write_reg(ddwg_pkg::CSR_ALPHA, 0);
      write_reg(ddwg_pkg::CSR_PROFILE, 64);
      send_bin(16'h7FFF, 16'h7FFF);
      send_bin(16'h8000, 16'h8000);
      send_bin(16'h0000, 16'h0000);
      send_bin(16'hFFFF, 16'h0001);
      send_bin(16'h8000, 16'h7FFF);
      for (int i = 5; i < 100; i++) send_bin(random_sample(2), random_sample(2));
      drain_results();
      write_reg(ddwg_pkg::CSR_PROFILE, 127);
      for (int i = 100; i < 180; i++) send_bin(random_sample(i % 4), random_sample(2));
      drain_results();
      write_reg(ddwg_pkg::CSR_PROFILE, 0);
      // bins 180..189 stay silent so their noise floor is clamped to one
      for (int i = 180; i < 190; i++) send_bin(16'h0000, 16'h0000);
      for (int i = 190; i < NBINS; i++) send_bin(random_sample(0), random_sample(0));
      drain_results();
   endtask

   // gain at both alpha extremes with extreme bins
   task automatic test_gain_extremes();
      write_reg(ddwg_pkg::CSR_ALPHA, 32767);
      write_reg(ddwg_pkg::CSR_PROFILE, 1);
      send_bin(16'h7FFF, 16'h7FFF);
      send_bin(16'h8000, 16'h8000);
      send_bin(16'h0000, 16'h0000);
      send_bin(16'h8000, 16'h7FFF);
      send_bin(16'h0001, 16'hFFFF);
      drain_results();
      write_reg(ddwg_pkg::CSR_ALPHA, 0);
      send_bin(16'h7FFF, 16'h8000);
      send_bin(16'h8000, 16'h8000);
      send_bin(16'h0000, 16'h0000);
      send_bin(16'h0003, 16'hFFFD);
      send_bin(16'h7FFF, 16'h7FFF);
      drain_results();
   endtask

   // random bins over several alpha settings, with one long output hold-off
   task automatic test_random_filtering();
      int alpha_set[5];
      alpha_set = '{ 32113, 0, 32767, 16384, 0 };
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(ddwg_pkg::CSR_ALPHA, (ph == 4) ? $urandom_range(0, 32767) : alpha_set[ph]);
         if (ph == 3) write_reg(ddwg_pkg::CSR_PROFILE, $urandom_range(1, 64));
         if (ph == 2) hold_request = 1'b1;
         for (int i = 0; i < 130; i++)
            send_bin(random_sample($urandom_range(0, 3)), random_sample($urandom_range(0, 3)));
         drain_results();
      end
   endtask

   // result checking and output stalls
   always @(posedge clock) begin
      bin_result_type exp_bin;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: data=%h", rsp_tdata);
         end else begin
            exp_bin = pending_bins.pop_front();
            if (rsp_tdata[15:0] !== exp_bin.re || rsp_tdata[31:16] !== exp_bin.im ||
                rsp_tdata[46:32] !== exp_bin.gain || rsp_tuser !== exp_bin.filt ||
                rsp_tlast !== exp_bin.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp re=%h im=%h gain=%h filt=%b last=%b, ",
                            "got re=%h im=%h gain=%h filt=%b last=%b"},
                           exp_bin.re, exp_bin.im, exp_bin.gain, exp_bin.filt, exp_bin.last,
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[46:32],
                           rsp_tuser, rsp_tlast);
            end
         end
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 200);
      end else mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      mismatches   = 0;
      idle_cycles  = 0;
      burst_left   = 0;
      hold_left    = 0;
      hold_request = 1'b0;
      stall_mode   = 0;
      mode_left    = 0;
      frame_count  = 0;
      profile_done = 1'b0;
      bin_idx      = 0;
      alpha_w      = 32113;
      profile_len  = 13;
      for (int j = 0; j < NBINS; j++) begin
         noise_acc[j] = 0;
         noise_lvl[j] = 0;
         clean_lvl[j] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_noise_profile();
      test_gain_extremes();
      test_random_filtering();

      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_bins.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: decision_directed_wiener_gain.f
rtl/ddwg_pkg.sv
rtl/ddwg_ram.sv
rtl/decision_directed_wiener_gain.sv
rtl/ddwg_checker.sv
verif/tb_decision_directed_wiener_gain.sv
